// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Helper macros for the concurrent assertions of the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== src/sksrd_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted key set package
// Shared constants, types and codes for the sorted key set block.
// ----------------------------------------------------------------------------
`default_nettype none
package sksrd_pkg;
  localparam int MaxKeys  = 256;
  localparam int KeyBytes = 32;
  localparam int Words    = 4;
  localparam int IdxW     = $clog2(MaxKeys);
  localparam int CntW     = $clog2(MaxKeys + 1);
  localparam int AddrW    = $clog2(MaxKeys * Words);

  typedef logic [63:0] word_t;
  typedef logic [255:0] key_t;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DIGEST = 2'd1,
    FUNC_FIND   = 2'd2,
    FUNC_READ   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_ZERO  = 3'd1,
    ST_DUP   = 3'd2,
    ST_FULL  = 3'd3,
    ST_ERROR = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_SHIFT_RD, S_SHIFT_WR, S_INS_WR,
    S_MOD, S_XOR_RD, S_XOR_ACC, S_DONE
  } state_t;

  function automatic word_t word_mask(input int w);
    int nb;
    nb = KeyBytes - 8 * w;
    if (nb >= 8) return '1;
    if (nb <= 0) return '0;
    return ~64'd0 << (64 - 8 * nb);
  endfunction
endpackage
`default_nettype wire

// ===== src/sksrd_ram.sv =====
// ----------------------------------------------------------------------------
// Key store memory
// One-port 64-bit word memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module sksrd_ram
  import sksrd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AddrW-1:0] addr,
  input  wire word_t            wdata,
  output word_t                 rdata
);
  word_t mem [MaxKeys*Words];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== src/sorted_key_set_range_digest.sv =====
// Insert and find scan or shift the stored keys word by word; digest reads each word of
// the range; read first reduces range_low modulo the set size, then reads that one key.
// The result is registered in the done state and input is refused until it is taken.
// One operation at a time; the one-port key memory and one 64-bit compare
// set the pace. Reset clears the key count and control state; the key
// memory needs no clearing.
// ----------------------------------------------------------------------------
// Sorted key set with range XOR digest
// Sequencer walking a one-port word memory with one 64-bit compare unit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module sorted_key_set_range_digest
  import sksrd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // func[1:0], key_word_0..3, range_low, range_high
  input  wire logic [279:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // status[2:0], position, set_size, span_count, data_word_0..3, zero pad
  output logic [287:0]      out_tdata
);
  state_t state_r, state_nxt;
  logic [1:0] func_r;
  word_t key_r [Words];
  logic [IdxW-1:0] lo_r, hi_r;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [CntW-1:0] idx_r;
  logic [1:0] w_r;
  logic [8:0] mod_r;
  word_t acc_r [Words];
  logic [2:0] st_r;
  logic [IdxW-1:0] pos_r;
  logic [8:0] span_r;
  logic ram_we;
  logic [AddrW-1:0] ram_addr;
  word_t ram_wd, ram_rd;

  sksrd_ram u_ram (.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wd),
                   .rdata(ram_rd));

  logic key_zero;
  assign key_zero = (key_r[0] | key_r[1] | key_r[2] | key_r[3]) == '0;
  logic lt, gt;
  assign lt = ram_rd < key_r[w_r];
  assign gt = ram_rd > key_r[w_r];
  assign in_tready = (state_r == S_IDLE);

  func_t in_func;
  assign in_func = func_t'(in_tdata[1:0]);
  logic digest_bad;
  assign digest_bad = (in_tdata[265:258] > in_tdata[273:266]) ||
                      (CntW'(in_tdata[273:266]) >= cnt_r);
  logic last_w;
  assign last_w = (w_r == 2'(Words - 1));

  assign cnt_nxt = (state_r == S_INS_WR && last_w) ? cnt_r + CntW'(1) : cnt_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          case (in_func)
            FUNC_DIGEST: state_nxt = digest_bad ? S_DONE : S_XOR_RD;
            FUNC_READ:   state_nxt = (cnt_r == '0) ? S_DONE : S_MOD;
            default:     state_nxt = S_SCAN_RD;
          endcase
        end
      end
      S_SCAN_RD: begin
        if (func_r != FUNC_READ && key_zero) begin
          state_nxt = S_DONE;
        end else if (idx_r >= cnt_r) begin
          if (func_r == FUNC_FIND || cnt_r >= CntW'(MaxKeys)) state_nxt = S_DONE;
          else state_nxt = S_INS_WR;
        end else begin
          state_nxt = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (gt && func_r == FUNC_INSERT) begin
          state_nxt = (cnt_r >= CntW'(MaxKeys)) ? S_DONE : S_SHIFT_RD;
        end else if (lt || gt || !last_w) begin
          state_nxt = S_SCAN_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SHIFT_RD: state_nxt = S_SHIFT_WR;
      S_SHIFT_WR: begin
        if (last_w && idx_r[IdxW-1:0] == pos_r) state_nxt = S_INS_WR;
        else state_nxt = S_SHIFT_RD;
      end
      S_INS_WR: if (last_w) state_nxt = S_DONE;
      S_MOD: if (mod_r < 9'(cnt_r)) state_nxt = S_XOR_RD;
      S_XOR_RD: state_nxt = S_XOR_ACC;
      S_XOR_ACC: begin
        if (last_w && idx_r[IdxW-1:0] == hi_r) state_nxt = S_DONE;
        else state_nxt = S_XOR_RD;
      end
      S_DONE: if (out_tvalid && out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  logic [AddrW-1:0] base;
  assign base = AddrW'({idx_r[IdxW-1:0], w_r});

  always_comb begin
    ram_we = 1'b0;
    ram_addr = base;
    ram_wd = key_r[w_r];
    case (state_r)
      S_SHIFT_WR: begin
        ram_we = 1'b1;
        ram_addr = AddrW'({idx_r[IdxW-1:0] + IdxW'(1), w_r});
        ram_wd = ram_rd;
      end
      S_INS_WR: ram_we = 1'b1;
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      out_tvalid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            func_r <= in_tdata[1:0];
            for (int w = 0; w < Words; w++) begin
              key_r[w] <= in_tdata[2 + 64*w +: 64] & word_mask(w);
              acc_r[w] <= '0;
            end
            lo_r <= in_tdata[265:258];
            hi_r <= in_tdata[273:266];
            idx_r <= (in_func == FUNC_DIGEST) ? CntW'(in_tdata[265:258]) : '0;
            mod_r <= 9'(in_tdata[265:258]);
            w_r <= '0;
            span_r <= '0;
            pos_r <= '0;
            if ((in_func == FUNC_DIGEST && digest_bad) ||
                (in_func == FUNC_READ && cnt_r == '0)) begin
              st_r <= ST_ERROR;
            end else begin
              st_r <= ST_OK;
            end
          end
        end
        S_SCAN_RD: begin
          if (func_r != FUNC_READ && key_zero) begin
            st_r <= (func_r == FUNC_INSERT) ? ST_ZERO : ST_ERROR;
          end else if (idx_r >= cnt_r) begin
            if (func_r == FUNC_FIND) begin
              st_r <= ST_ERROR;
            end else if (cnt_r >= CntW'(MaxKeys)) begin
              st_r <= ST_FULL;
            end else begin
              pos_r <= IdxW'(cnt_r);
              idx_r <= cnt_r;
              w_r <= '0;
            end
          end
        end
        S_SCAN_CMP: begin
          if (gt && func_r == FUNC_INSERT) begin
            // Sorted order: greater means the key is absent.
            if (cnt_r >= CntW'(MaxKeys)) begin
              st_r <= ST_FULL;
            end else begin
              pos_r <= idx_r[IdxW-1:0];
              idx_r <= cnt_r - CntW'(1);
              w_r <= '0;
            end
          end else if (lt || gt) begin
            idx_r <= idx_r + CntW'(1);
            w_r <= '0;
          end else if (last_w) begin
            st_r <= (func_r == FUNC_INSERT) ? ST_DUP : ST_OK;
            pos_r <= idx_r[IdxW-1:0];
          end else begin
            w_r <= w_r + 2'd1;
          end
        end
        S_SHIFT_WR: begin
          if (!last_w) begin
            w_r <= w_r + 2'd1;
          end else begin
            w_r <= '0;
            if (idx_r[IdxW-1:0] != pos_r) idx_r <= idx_r - CntW'(1);
          end
        end
        S_INS_WR: begin
          if (!last_w) w_r <= w_r + 2'd1;
        end
        S_MOD: begin
          if (mod_r >= 9'(cnt_r)) begin
            mod_r <= mod_r - 9'(cnt_r);
          end else begin
            idx_r <= CntW'(mod_r);
            pos_r <= mod_r[IdxW-1:0];
            lo_r <= mod_r[IdxW-1:0];
            hi_r <= mod_r[IdxW-1:0];
          end
        end
        S_XOR_ACC: begin
          acc_r[w_r] <= acc_r[w_r] ^ ram_rd;
          if (!last_w) begin
            w_r <= w_r + 2'd1;
          end else if (idx_r[IdxW-1:0] == hi_r) begin
            if (func_r == FUNC_DIGEST) begin
              pos_r <= lo_r;
              span_r <= 9'(hi_r) - 9'(lo_r) + 9'd1;
            end
          end else begin
            w_r <= '0;
            idx_r <= idx_r + CntW'(1);
          end
        end
        S_DONE: begin
          if (!out_tvalid) begin
            out_tvalid <= 1'b1;
            out_tdata <= {3'd0, acc_r[3], acc_r[2], acc_r[1], acc_r[0], span_r,
                          9'(cnt_r), pos_r, st_r};
          end else if (out_tready) begin
            out_tvalid <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  `ASSERT_IMPL(a_cnt_max, clk, rst_n, 1'b1, cnt_r <= CntW'(MaxKeys))
  `ASSERT_IMPL(a_busy, clk, rst_n, state_r != S_IDLE, !in_tready)
  `ASSERT_NEXT(a_cnt_step, clk, rst_n, state_r == S_IDLE, cnt_r == $past(cnt_r))
endmodule
`default_nettype wire
